FILE: hdl/tksb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksb_pkg: shared types and constants of the top-k score board
// Field widths, command codes, cell operations and controller states.
// ----------------------------------------------------------------------------
package tksb_pkg;

    localparam int PLAYER_W = 32;
    localparam int SCORE_W  = 64;
    localparam int RANK_W   = 6;

    // input command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // contents of one board position
    typedef struct packed {
        logic                valid;
        logic [PLAYER_W-1:0] player;
        logic [SCORE_W-1:0]  score;
    } t_cell_data;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_CLEAR,
        OP_ROTATE
    } t_cell_op;

    // broadcast control bundle
    typedef struct packed {
        t_cell_op            op;
        logic [PLAYER_W-1:0] new_player;
        logic [SCORE_W-1:0]  new_score;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

endpackage

FILE: hdl/tksb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksb_cell: one board position
// Holds an entry, compares it with a broadcast new score, and on insert
// keeps, takes the new entry or takes its upper neighbor. On rotate it
// takes its lower neighbor so the board streams out through cell 0; on clear it empties.
// ----------------------------------------------------------------------------
module tksb_cell
    import tksb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_cell_data i_prev_data,
    input  logic       i_prev_keep,
    input  t_cell_data i_next_data,
    output t_cell_data o_data,
    output logic       o_keep
);

    t_cell_data r_data;
    t_cell_data n_data;

    // entry stays in place when it ranks at or above the new score
    assign o_keep = r_data.valid && (r_data.score >= i_ctl.new_score);
    assign o_data = r_data;

    // next contents
    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            OP_INSERT: begin
                if (o_keep) begin
                    n_data = r_data;
                end else if (i_prev_keep) begin
                    n_data.valid  = 1'b1;
                    n_data.player = i_ctl.new_player;
                    n_data.score  = i_ctl.new_score;
                end else begin
                    n_data = i_prev_data;
                end
            end
            OP_CLEAR:  n_data = '0;
            OP_ROTATE: n_data = i_next_data;
            default:   n_data = r_data;
        endcase
    end

    // storage, board empty after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

endmodule

FILE: hdl/top_k_score_board.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_score_board: sorted board of the highest scores
// A row of cells keeps up to KEEP_COUNT entries in descending score order;
// ties keep the older entry first. After every transaction the whole board
// streams out, one rank per result.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// --------+-----+--------------------+---------------------------------------
// input   | in  | i_valid / o_stall  | i_command, i_player_id, i_score
// result  | out | o_valid / i_stall  | o_rank, o_entry_valid, o_entry_player,
//         |     |                    | o_entry_score, o_last
//
// an input transaction updates all cells at once, then KEEP_COUNT
// results follow, one per cycle while i_stall is low, by rotating the
// cell row through cell 0.
// o_stall is high while a board run is being emitted.
// synchronous active-low reset empties the board.
// an output stall freezes the rotation; the result register holds its data.
// ----------------------------------------------------------------------------
module top_k_score_board
    import tksb_pkg::*;
#(
    parameter int KEEP_COUNT = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_command,
    input  logic [PLAYER_W-1:0] i_player_id,
    input  logic [SCORE_W-1:0]  i_score,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [RANK_W-1:0]   o_rank,
    output logic                o_entry_valid,
    output logic [PLAYER_W-1:0] o_entry_player,
    output logic [SCORE_W-1:0]  o_entry_score,
    output logic                o_last
);

    localparam int CNT_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(KEEP_COUNT - 1);

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic [RANK_W-1:0]   r_rank;
    logic                r_entry_valid;
    logic [PLAYER_W-1:0] r_entry_player;
    logic [SCORE_W-1:0]  r_entry_score;
    logic                r_last;

    logic       w_accept;
    logic       w_load_out;
    t_cell_ctl  w_ctl;
    t_cell_data w_cell [KEEP_COUNT];
    logic       w_keep [KEEP_COUNT];

    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_load_out = (r_state == ST_EMIT) && (!r_out_valid || !i_stall);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_EMIT;
            ST_EMIT: if (w_load_out && (r_cnt == LAST_CNT)) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // cell control
    always_comb begin
        w_ctl.new_player = i_player_id;
        w_ctl.new_score  = i_score;
        case (r_state)
            ST_IDLE: begin
                if (!w_accept) begin
                    w_ctl.op = OP_HOLD;
                end else if (i_command == CMD_CLEAR) begin
                    w_ctl.op = OP_CLEAR;
                end else begin
                    w_ctl.op = OP_INSERT;
                end
            end
            ST_EMIT: w_ctl.op = w_load_out ? OP_ROTATE : OP_HOLD;
            default: w_ctl.op = OP_HOLD;
        endcase
    end

    // state and result counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt <= '0;
            end else if (w_load_out) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // row of cells, cell 0 is rank 0
    for (genvar g = 0; g < KEEP_COUNT; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == KEEP_COUNT - 1) ? 0 : g + 1;
        tksb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_prev_data ((g == 0) ? '0 : w_cell[PREV]),
            .i_prev_keep ((g == 0) ? 1'b1 : w_keep[PREV]),
            .i_next_data (w_cell[NEXT]),
            .o_data      (w_cell[g]),
            .o_keep      (w_keep[g])
        );
    end

    // result register, empty positions read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_rank         <= RANK_W'(r_cnt);
            r_entry_valid  <= w_cell[0].valid;
            r_entry_player <= w_cell[0].valid ? w_cell[0].player : '0;
            r_entry_score  <= w_cell[0].valid ? w_cell[0].score : '0;
            r_last         <= (r_cnt == LAST_CNT);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_rank         = r_rank;
    assign o_entry_valid  = r_entry_valid;
    assign o_entry_player = r_entry_player;
    assign o_entry_score  = r_entry_score;
    assign o_last         = r_last;

    // board shape check: no gaps and descending scores
    logic w_board_bad;
    always_comb begin
        w_board_bad = 1'b0;
        for (int i = 1; i < KEEP_COUNT; i++) begin
            if (w_cell[i].valid && !w_cell[i-1].valid) begin
                w_board_bad = 1'b1;
            end
            if (w_cell[i].valid && (w_cell[i].score > w_cell[i-1].score)) begin
                w_board_bad = 1'b1;
            end
        end
    end

    a_board_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_board_bad)
        else $error("board out of order or has a gap");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EMIT) && (r_cnt == '0))
        else $error("board run did not start at rank zero");

    a_last_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_rank == RANK_W'(KEEP_COUNT - 1)))
        else $error("last flag on wrong rank");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_entry_valid) |-> (o_entry_score == '0) && (o_entry_player == '0))
        else $error("empty position carries data");

endmodule
